[hdl/modexp_pkg.sv]
// shared constants for the modular exponentiation unit
package modexp_pkg;

    // default operand width of base, exponent and modulus
    localparam int OPERAND_BITS = 31;

endpackage

[hdl/modular_exponentiation_unit.sv]
// modular exponentiation unit: right-to-left square-and-multiply with bit-serial products
//
// Input channel: i_in_valid / o_in_ready carry i_base, i_exponent and i_modulus.
// Output channel: o_out_valid / i_out_ready carry o_power_mod and o_modulus_error.
// A transfer happens on a rising edge with valid and ready both high.
//
// After a transfer the base is reduced by the modulus in one pass over its bits.
// Then each exponent bit up to the highest set bit takes one pass, in which the
// result product and the next square are formed side by side, one multiplier bit
// a cycle from a shift register of the square.
// A zero modulus skips the passes and returns 0 with o_modulus_error set.
// One item is worked on at a time; o_in_ready is high whenever the unit is idle, also
// while a finished result waits in the output register.
// If the receiver stalls, the next result waits in its final state until the output
// register is free, and no new item is taken meanwhile.
// Reset (i_rst_n low, synchronous) empties the output register and returns to idle.
module modular_exponentiation_unit #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OPERAND_BITS-1:0] i_base,
    input  logic [OPERAND_BITS-1:0] i_exponent,
    input  logic [OPERAND_BITS-1:0] i_modulus,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OPERAND_BITS-1:0] o_power_mod,
    output logic                    o_modulus_error
);
    import modexp_pkg::*;

    localparam int W  = OPERAND_BITS;
    localparam int CW = $clog2(OPERAND_BITS);
    localparam logic [CW-1:0] LAST_BIT = CW'(OPERAND_BITS - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_MUL    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // one multiplier bit of (acc * 2 + bit * a) mod m, with acc and a below m
    function automatic logic [W-1:0] mod_step(input logic [W-1:0] acc,
                                             input logic [W-1:0] a,
                                             input logic         b,
                                             input logic [W-1:0] m);
        logic [W+1:0] t;
        logic [W+1:0] m1;
        logic [W+1:0] m2;
        logic [W+1:0] r;
        t  = {1'b0, acc, 1'b0} + (b ? {2'b00, a} : '0);
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (t >= m2) begin
            r = t - m2;
        end else if (t >= m1) begin
            r = t - m1;
        end else begin
            r = t;
        end
        return r[W-1:0];
    endfunction

    logic [1:0]    r_state, n_state;
    logic [W-1:0]  r_mod, n_mod;
    logic [W-1:0]  r_sq, n_sq;
    logic [W-1:0]  r_res, n_res;
    logic [W-1:0]  r_acc_s, n_acc_s;
    logic [W-1:0]  r_acc_r, n_acc_r;
    logic [W-1:0]  r_bsh, n_bsh;
    logic [W-1:0]  r_expo, n_expo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_err, n_err;
    logic [W-1:0]  r_pm, n_pm;
    logic          r_pm_err, n_pm_err;
    logic          r_out_valid, n_out_valid;

    logic [W-1:0] step_s, step_r, a_s, new_sq, new_res;
    logic [W-1:0] expo_next;
    logic         pass_end, out_free;

    // datapath of one bit step for both products
    always_comb begin
        a_s       = (r_state == S_REDUCE) ? W'(1) : r_sq;
        step_s    = mod_step(r_acc_s, a_s, r_bsh[W-1], r_mod);
        step_r    = mod_step(r_acc_r, r_res, r_bsh[W-1], r_mod);
        pass_end  = (r_cnt == LAST_BIT);
        new_sq    = step_s;
        new_res   = r_expo[0] ? step_r : r_res;
        expo_next = r_expo >> 1;
        out_free  = !r_out_valid || i_out_ready;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_power_mod     = r_pm;
    assign o_modulus_error = r_pm_err;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mod       = r_mod;
        n_sq        = r_sq;
        n_res       = r_res;
        n_acc_s     = r_acc_s;
        n_acc_r     = r_acc_r;
        n_bsh       = r_bsh;
        n_expo      = r_expo;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_pm        = r_pm;
        n_pm_err    = r_pm_err;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mod   = i_modulus;
                    n_expo  = i_exponent;
                    n_acc_s = '0;
                    n_acc_r = '0;
                    n_bsh   = i_base;
                    n_cnt   = '0;
                    n_res   = (i_modulus == W'(1)) ? '0 : W'(1);
                    if (i_modulus == '0) begin
                        n_err   = 1'b1;
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE, S_MUL: begin
                n_acc_s = step_s;
                n_acc_r = step_r;
                n_bsh   = r_bsh << 1;
                n_cnt   = r_cnt + CW'(1);
                if (pass_end) begin
                    n_cnt   = '0;
                    n_acc_s = '0;
                    n_acc_r = '0;
                    n_sq    = new_sq;
                    n_bsh   = new_sq;
                    if (r_state == S_MUL) begin
                        n_res  = new_res;
                        n_expo = expo_next;
                        n_state = (expo_next == '0) ? S_DONE : S_MUL;
                    end else begin
                        n_state = (r_expo == '0) ? S_DONE : S_MUL;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_pm        = r_res;
                    n_pm_err    = r_err;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mod    <= n_mod;
        r_sq     <= n_sq;
        r_res    <= n_res;
        r_acc_s  <= n_acc_s;
        r_acc_r  <= n_acc_r;
        r_bsh    <= n_bsh;
        r_expo   <= n_expo;
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        r_pm     <= n_pm;
        r_pm_err <= n_pm_err;
    end

    // accumulators and the square stay reduced during a multiply pass
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_acc_s < r_mod && r_acc_r < r_mod && r_sq < r_mod))
        else $error("accumulator or square not below modulus");

    // a finished result is below the modulus
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_err) |-> (r_res < r_mod))
        else $error("result not below modulus");

    // finishing without error means the exponent was used up
    a_expo_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_err) |-> (r_expo == '0))
        else $error("done with exponent bits left");

    // an error result carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pm_err) |-> (r_pm == '0))
        else $error("error result is not zero");

endmodule

[tb/modular_exponentiation_unit_tb.sv]
// testbench for the modular exponentiation unit: scoreboard, handshake drivers and stimulus
`timescale 1ns / 100ps

typedef logic [modexp_pkg::OPERAND_BITS-1:0] t_operand;

typedef struct {
    t_operand power;
    logic     modulus_error;
} t_power_result;

// keeps the awaited results in order and compares them with what comes out
class modexp_scoreboard;
    t_power_result awaited_powers[$];
    int            failures = 0;

    // base^exponent mod modulus, square-and-multiply with 64-bit products
    static function t_power_result raise_mod(t_operand b, t_operand e, t_operand m);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned mm;
        t_power_result   r;
        if (m == '0) begin
            r.power = '0;
            r.modulus_error = 1'b1;
            return r;
        end
        mm = m;
        acc = 64'd1 % mm;
        sq = 64'(b) % mm;
        for (int i = 0; i < modexp_pkg::OPERAND_BITS; i++) begin
            if (e[i]) acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        r.power = t_operand'(acc);
        r.modulus_error = 1'b0;
        return r;
    endfunction

    function void note_operands(t_operand b, t_operand e, t_operand m);
        awaited_powers.push_back(raise_mod(b, e, m));
    endfunction

    function void check_power(t_operand power, logic modulus_error);
        t_power_result exp_r;
        if (awaited_powers.size() == 0) begin
            $error("result with nothing awaited: power_mod %0d, modulus_error %0b",
                   power, modulus_error);
            failures++;
            return;
        end
        exp_r = awaited_powers.pop_front();
        if (power !== exp_r.power) begin
            $error("power_mod mismatch: expected %0d, actual %0d", exp_r.power, power);
            failures++;
        end
        if (modulus_error !== exp_r.modulus_error) begin
            $error("modulus_error mismatch: expected %0b, actual %0b",
                   exp_r.modulus_error, modulus_error);
            failures++;
        end
    endfunction

    function int outstanding();
        return awaited_powers.size();
    endfunction
endclass

module modular_exponentiation_unit_tb;

    localparam int OPERAND_BITS   = modexp_pkg::OPERAND_BITS;
    localparam int IDLE_PERCENT   = 21;
    localparam int RANDOM_ITEMS   = 272;
    localparam int HOLDOFF_AT     = 60;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES   = 1000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_operand i_base = '0;
    t_operand i_exponent = '0;
    t_operand i_modulus = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_operand o_power_mod;
    logic     o_modulus_error;

    modexp_scoreboard sb = new();
    int  taken = 0;
    bit  steady = 1'b0;
    bit  held = 1'b0;

    modular_exponentiation_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_base(i_base),
        .i_exponent(i_exponent),
        .i_modulus(i_modulus),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_power_mod(o_power_mod),
        .o_modulus_error(o_modulus_error)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one operand set, entered and left at a falling edge
    task automatic send_operands(input t_operand b, input t_operand e, input t_operand m);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base <= b;
        i_exponent <= e;
        i_modulus <= m;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_operands(b, e, m);
        taken++;
        @(negedge i_clk);
    endtask

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_power(o_power_mod, o_modulus_error);
    end

    // receiver: random stalls, one long hold-off to back the unit up
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && taken >= HOLDOFF_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // run limit
    initial begin
        #15_000_000;
        $display("** modular_exponentiation_unit: FAILED **");
        $finish;
    end

    // reset, directed and random stimulus, drain and verdict
    initial begin
        int       ew;
        int       sel;
        int       mw;
        t_operand b;
        t_operand e;
        t_operand m;
        logic [31:0] mask;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes and special cases
        send_operands('0, '0, '0);                   // zero modulus
        send_operands('1, '1, '0);                   // zero modulus, busy operands
        send_operands(31'd5, '0, 31'd1);             // zero exponent, modulus one
        send_operands(31'd5, '0, 31'd7);             // zero exponent
        send_operands('0, '0, 31'd13);               // zero to the zero
        send_operands('0, '1, '1);                   // zero base
        send_operands('1, 31'd1, '1);                // base equal to modulus
        send_operands('1, '1, '1 - 31'd1);           // base above modulus
        send_operands(31'd12345, 31'd1, 31'd1);      // modulus one
        send_operands(31'd3, '1, 31'd2);
        send_operands('1, 31'd2, 31'd1000003);
        send_operands(31'd2, 31'd30, '1);
        send_operands(31'd100, 31'd5, 31'd7);        // base above modulus
        send_operands('1, '1, '1 - 31'd2);
        send_operands(31'd2, 31'h4000_0000, 31'd97); // only the top exponent bit
        send_operands(31'd7, 31'd1, 31'd2);
        send_operands(31'd1, '1, 31'd5);
        send_operands('1 - 31'd1, '1, '1);           // base one below modulus

        // random part, exponent length spread so that short and full-length exponents mix
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 200 && n < 240);

            ew = $urandom_range(OPERAND_BITS, 0);
            mask = (32'd1 << ew) - 32'd1;
            e = (ew == 0) ? '0 : t_operand'(($urandom & mask) | (32'd1 << (ew - 1)));

            sel = $urandom_range(99);
            if (sel < 3) begin
                m = '0;
            end else if (sel < 6) begin
                m = 31'd1;
            end else if (sel < 10) begin
                m = '1;
            end else if (sel < 40) begin
                mw = $urandom_range(16, 1);
                m = t_operand'($urandom & ((32'd1 << mw) - 32'd1));
            end else begin
                m = t_operand'($urandom);
            end

            sel = $urandom_range(99);
            if (sel < 8)
                b = '0;
            else if (sel < 16)
                b = '1;
            else if (sel < 50 && m != '0)
                b = t_operand'($urandom % m);
            else
                b = t_operand'($urandom);

            send_operands(b, e, m);
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // wait for every awaited result, then watch for strays
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("** modular_exponentiation_unit: PASSED **");
        end else begin
            $display("** modular_exponentiation_unit: FAILED **");
        end
        $finish;
    end

endmodule

[modular_exponentiation_unit.f]
hdl/modexp_pkg.sv
hdl/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_tb.sv
